[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [15:0] MSS_RESET      = 16'd536;
  localparam logic [2:0]  IWS_RESET      = 3'd1;
  localparam logic [7:0]  DUP_THR_RESET  = 8'd3;
  localparam logic [31:0] INIT_SS_RESET  = 32'd65535;

  localparam logic [1:0] REG_SEGMENT_SIZE   = 2'd0;
  localparam logic [1:0] REG_INIT_WINDOW    = 2'd1;
  localparam logic [1:0] REG_DUP_ACK_THRESH = 2'd2;
  localparam logic [1:0] REG_INIT_SSTHRESH  = 2'd3;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_NEW_ACK  = 2'd1,
    OP_DUP_ACK  = 2'd2,
    OP_TIMEOUT  = 2'd3
  } tcw_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } tcw_state_t;

  typedef struct packed {
    logic [15:0] segment_size;
    logic [2:0]  initial_window_segments;
    logic [7:0]  dup_ack_threshold;
    logic [31:0] initial_slow_start_threshold;
  } tcw_cfg_t;

endpackage

`default_nettype wire

[src/tcw_intf.sv]
`default_nettype none

interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  dup_count;
  logic        socket_closed;
  logic        all_data_acked;
  logic [31:0] receiver_window;

  modport source (
    output valid, op, dup_count, socket_closed, all_data_acked, receiver_window,
    input  ready
  );
  modport sink (
    input  valid, op, dup_count, socket_closed, all_data_acked, receiver_window,
    output ready
  );
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] congestion_window;
  logic [31:0] threshold;
  logic [31:0] send_window;
  logic        retransmit;
  logic        double_rto;

  modport source (
    output valid, congestion_window, threshold, send_window, retransmit, double_rto,
    input  ready
  );
  modport sink (
    input  valid, congestion_window, threshold, send_window, retransmit, double_rto,
    output ready
  );
endinterface

`default_nettype wire

[src/tcw_cfg.sv]
`default_nettype none

module tcw_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output tcw_pkg::tcw_cfg_t               cfg
);
  import tcw_pkg::*;

  tcw_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.segment_size                 <= MSS_RESET;
      cfg_r.initial_window_segments      <= IWS_RESET;
      cfg_r.dup_ack_threshold            <= DUP_THR_RESET;
      cfg_r.initial_slow_start_threshold <= INIT_SS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SEGMENT_SIZE:   cfg_r.segment_size <= pwdata[15:0];
        REG_INIT_WINDOW:    cfg_r.initial_window_segments <= pwdata[2:0];
        REG_DUP_ACK_THRESH: cfg_r.dup_ack_threshold <= pwdata[7:0];
        REG_INIT_SSTHRESH:  cfg_r.initial_slow_start_threshold <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEGMENT_SIZE:   prdata = {16'd0, cfg_r.segment_size};
      REG_INIT_WINDOW:    prdata = {29'd0, cfg_r.initial_window_segments};
      REG_DUP_ACK_THRESH: prdata = {24'd0, cfg_r.dup_ack_threshold};
      REG_INIT_SSTHRESH:  prdata = cfg_r.initial_slow_start_threshold;
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/tcw_div.sv]
`default_nettype none

module tcw_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import tcw_pkg::*;

  logic [31:0]          rem_r;
  logic [31:0]          quo_r;
  logic [31:0]          dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [32:0]          shifted;
  logic [32:0]          diff;
  logic                 ge;
  logic                 last;

  assign shifted  = {rem_r, quo_r[31]};
  assign diff     = shifted - {1'b0, dsr_r};
  assign ge       = shifted >= {1'b0, dsr_r};
  assign last     = cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r & last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : shifted[31:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

endmodule

`default_nettype wire

[src/tcp_tahoe_congestion_window_top.sv]
// TCP Tahoe congestion window engine.
// Input channel in_ch (valid/ready): one event beat per op, with the duplicate
// ack count, socket state flags and the advertised receiver window.
// Output channel out_ch (valid/ready): exactly one result beat per input beat,
// in order: window, threshold, send window and the retransmit / RTO flags.
// Configuration: APB write/read of four registers at byte offsets 0, 4, 8, 12;
// pready is tied high. Write only while no event is in flight.
// Start, dup ack and timeout events and new acks in slow start go from the
// accepting idle state through exec to out, which loads the result register.
// A new ack in congestion avoidance runs a bit-serial restoring divide of
// mss*mss by the window, one quotient bit per cycle, in the div state between
// exec and out. One event is in flight at a time; the next beat is accepted
// the cycle after the previous result is registered.
// If out_ch stalls, the result register holds its beat, one more input beat is
// accepted and processed, and the engine waits with that result until the
// register frees up.
// Reset (synchronous, rst_n low): window 0, threshold 65535, registers back to
// 536 / 1 / 3 / 65535, both channels empty.
`default_nettype none
`include "assert_macros.svh"

module tcp_tahoe_congestion_window_top (
  input  logic                            clk,
  input  logic                            rst_n,
  tcw_in_if.sink                          in_ch,
  tcw_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import tcw_pkg::*;

  tcw_cfg_t    cfg;
  tcw_state_t  state_r, state_nxt;

  logic [1:0]  op_r;
  logic [7:0]  dup_r;
  logic        closed_r;
  logic        acked_r;
  logic [31:0] rwnd_r;

  logic [31:0] win_r, win_nxt;
  logic [31:0] ss_r, ss_nxt;
  logic        retx_r, retx_nxt;
  logic        dbl_r, dbl_nxt;

  logic        out_valid_r;
  logic [31:0] out_cw_r;
  logic [31:0] out_ss_r;
  logic [31:0] out_snd_r;
  logic        out_retx_r;
  logic        out_dbl_r;

  logic        in_fire;
  logic        in_rdy;
  logic        out_free;
  logic        out_load;
  logic        need_div;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;
  logic [31:0] sq;
  logic [31:0] inc;
  logic [31:0] add_val;
  logic [32:0] add_sum;
  logic [31:0] add_sat;
  logic [31:0] half;
  logic [31:0] two_mss;
  logic [31:0] loss_ss;
  logic [31:0] init_win;

  tcw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tcw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sq),
    .divisor  (win_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ch.ready = in_rdy;
  assign in_fire     = in_ch.valid & in_rdy;
  assign out_free    = ~out_valid_r | out_ch.ready;
  assign need_div    = (op_r == OP_NEW_ACK) && !(win_r < ss_r) && (win_r != 32'd0);

  assign sq       = {16'd0, cfg.segment_size} * {16'd0, cfg.segment_size};
  assign inc      = (div_quo == 32'd0) ? 32'd1 : div_quo;
  assign add_val  = (state_r == ST_DIV) ? inc : {16'd0, cfg.segment_size};
  assign add_sum  = {1'b0, win_r} + {1'b0, add_val};
  assign add_sat  = add_sum[32] ? '1 : add_sum[31:0];
  assign half     = {1'b0, win_r[31:1]};
  assign two_mss  = {15'd0, cfg.segment_size, 1'b0};
  assign loss_ss  = (half > two_mss) ? half : two_mss;
  assign init_win = {13'd0, {16'd0, cfg.initial_window_segments} * {3'd0, cfg.segment_size}};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = need_div ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_EXEC: div_start = need_div;
      ST_DIV:  ;
      ST_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    win_nxt  = win_r;
    ss_nxt   = ss_r;
    retx_nxt = retx_r;
    dbl_nxt  = dbl_r;
    if (state_r == ST_EXEC) begin
      retx_nxt = 1'b0;
      dbl_nxt  = 1'b0;
      case (op_r)
        OP_START: begin
          win_nxt = init_win;
          ss_nxt  = cfg.initial_slow_start_threshold;
        end
        OP_NEW_ACK: begin
          if (!need_div) begin
            win_nxt = add_sat;
          end
        end
        OP_DUP_ACK: begin
          if (dup_r == cfg.dup_ack_threshold) begin
            win_nxt  = {16'd0, cfg.segment_size};
            ss_nxt   = loss_ss;
            retx_nxt = 1'b1;
          end
        end
        OP_TIMEOUT: begin
          if (!closed_r && !acked_r) begin
            win_nxt  = {16'd0, cfg.segment_size};
            ss_nxt   = loss_ss;
            retx_nxt = 1'b1;
            dbl_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state_r == ST_DIV && div_done) begin
      win_nxt = add_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= '0;
      ss_r        <= INIT_SS_RESET;
      retx_r      <= 1'b0;
      dbl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      ss_r    <= ss_nxt;
      retx_r  <= retx_nxt;
      dbl_r   <= dbl_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_ch.op;
      dup_r    <= in_ch.dup_count;
      closed_r <= in_ch.socket_closed;
      acked_r  <= in_ch.all_data_acked;
      rwnd_r   <= in_ch.receiver_window;
    end
    if (out_load) begin
      out_cw_r   <= win_r;
      out_ss_r   <= ss_r;
      out_snd_r  <= (rwnd_r < win_r) ? rwnd_r : win_r;
      out_retx_r <= retx_r;
      out_dbl_r  <= dbl_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.congestion_window = out_cw_r;
  assign out_ch.threshold         = out_ss_r;
  assign out_ch.send_window       = out_snd_r;
  assign out_ch.retransmit        = out_retx_r;
  assign out_ch.double_rto        = out_dbl_r;

  `ASSERT_NEXT(a_accept_to_exec, in_fire, state_r == ST_EXEC, "accepted beat not executed")
  `ASSERT_NOW(a_div_done_in_div, div_done, state_r == ST_DIV, "divide done outside wait")
  `ASSERT_NOW(a_rto_implies_retx, out_valid_r && out_dbl_r, out_retx_r, "rto without retransmit")
  `ASSERT_NOW(a_send_le_cwnd, out_valid_r, out_snd_r <= out_cw_r, "send window above cwnd")

endmodule

`default_nettype wire
